// ----- src/ccc_pkg.sv -----
// Shared types and constants for the chamber condensation climate control block.
// Used by every module of the block; depends on nothing.
package ccc_pkg;

  // Field widths
  localparam int IDX_W   = 2;
  localparam int TEMP_W  = 15;
  localparam int HUM_W   = 14;
  localparam int RATIO_W = 16;
  localparam int PD_W    = 33;   // (T_in - T_out) * ratio
  localparam int LN_W    = 20;   // ln(RH/100) in Q16, signed
  localparam int QUOT_W  = 22;   // magnitude of the Magnus temperature term
  localparam int DIV_W   = 22;   // divisor 100 * (B + T)
  localparam int NUM_W   = 41;   // dividend A * |T| * 2^16

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_SURF_RATIO = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TEMP_LOW   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_TEMP_HIGH  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_HUMID_LOW  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_HUMID_HIGH = 3'd4;

  // Magnus and humidity constants, fixed point
  localparam int MAG_A_CENTI = 1727;
  localparam int MAG_B_CENTI = 23770;
  localparam int MAG_A_Q16   = 1131807;
  localparam int LN2_Q16     = 45426;
  localparam int RH_FULL     = 10000;
  localparam int RH_FLOOR    = 100;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [TEMP_W-1:0] t;
    logic [HUM_W-1:0]         h;
    logic signed [PD_W-1:0]   pd;
  } side_t;

  typedef struct packed {
    side_t                  s;
    logic signed [LN_W-1:0] ln;
  } lnside_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] t_lo;
    logic signed [TEMP_W-1:0] t_hi;
    logic [HUM_W-1:0]         h_lo;
    logic [HUM_W-1:0]         h_hi;
  } lim_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             fan;
    logic             heat;
    logic             risk;
  } result_t;

endpackage

// ----- src/ccc_ln.sv -----
// Seven-stage pipeline computing ln(RH/100) in Q16 from an interpolated table.
// Depends on ccc_pkg.
module ccc_ln import ccc_pkg::*; #(
  parameter int unsigned LN_TABLE_DEPTH = 256
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  side_t   side_i,
  output logic    valid_o,
  output lnside_t lnside_o
);

  localparam int AW   = $clog2(LN_TABLE_DEPTH + 1);
  localparam int IW   = $clog2(LN_TABLE_DEPTH);
  localparam int PW   = $clog2(RH_FULL * LN_TABLE_DEPTH);
  localparam int S1   = PW + 14;
  localparam longint M1 = ((64'sd1 <<< S1) + RH_FULL - 1) / RH_FULL;
  localparam int M1W  = S1 - 13;
  localparam int PR1W = PW + M1W;
  localparam int XW   = 30;
  localparam int S2   = XW + 14;
  localparam longint M2 = ((64'sd1 <<< S2) + RH_FULL - 1) / RH_FULL;
  localparam int M2W  = S2 - 13;
  localparam int PR2W = XW + M2W;

  // 2*atanh(z) series, z in Q30, result rounded to Q16
  function automatic longint ln_series(input longint z);
    longint z2;
    longint t;
    longint s;
    z2 = (z * z) >>> 30;
    t  = z;
    s  = z;
    t = (t * z2) >>> 30; s = s + t / 3;
    t = (t * z2) >>> 30; s = s + t / 5;
    t = (t * z2) >>> 30; s = s + t / 7;
    t = (t * z2) >>> 30; s = s + t / 9;
    t = (t * z2) >>> 30; s = s + t / 11;
    t = (t * z2) >>> 30; s = s + t / 13;
    t = (t * z2) >>> 30; s = s + t / 15;
    t = (t * z2) >>> 30; s = s + t / 17;
    t = (t * z2) >>> 30; s = s + t / 19;
    t = (t * z2) >>> 30; s = s + t / 21;
    t = (t * z2) >>> 30; s = s + t / 23;
    t = (t * z2) >>> 30; s = s + t / 25;
    t = (t * z2) >>> 30; s = s + t / 27;
    t = (t * z2) >>> 30; s = s + t / 29;
    t = (t * z2) >>> 30; s = s + t / 31;
    t = (t * z2) >>> 30; s = s + t / 33;
    t = (t * z2) >>> 30; s = s + t / 35;
    t = (t * z2) >>> 30; s = s + t / 37;
    t = (t * z2) >>> 30; s = s + t / 39;
    return (2 * s + 8192) >>> 14;
  endfunction

  // Table of ln(1 + k/D) in Q16
  logic [15:0] ln_rom [LN_TABLE_DEPTH+1];

  for (genvar k = 0; k <= LN_TABLE_DEPTH; k++) begin : g_rom
    localparam longint Z = (longint'(k) <<< 30) / (2 * longint'(LN_TABLE_DEPTH) + longint'(k));
    assign ln_rom[k] = 16'(ln_series(Z));
  end

  // Stage 1: clamp, normalise by doubling, scale the mantissa
  logic [HUM_W-1:0] hc;
  logic [2:0]       e_d;
  logic [20:0]      m_d;
  logic [HUM_W-1:0] pm_d;
  logic [PW-1:0]    p_d;

  always_comb begin
    if (side_i.h < HUM_W'(RH_FLOOR)) begin
      hc = HUM_W'(RH_FLOOR);
    end else if (side_i.h > HUM_W'(RH_FULL)) begin
      hc = HUM_W'(RH_FULL);
    end else begin
      hc = side_i.h;
    end
    e_d = 3'd7;
    for (int k = 7; k >= 0; k--) begin
      if (({7'b0, hc} << k) >= 21'(RH_FULL)) begin
        e_d = 3'(k);
      end
    end
    m_d  = {7'b0, hc} << e_d;
    pm_d = HUM_W'(m_d - 21'(RH_FULL));
    p_d  = PW'(32'(pm_d) * 32'(LN_TABLE_DEPTH));
  end

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  side_t s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q;
  logic [2:0] e1_q, e2_q, e3_q, e4_q, e5_q, e6_q;
  logic [PW-1:0] p1_q, p2_q;
  logic [PR1W-1:0] pr1_q;
  logic [IW-1:0] i3_q;
  logic [HUM_W-1:0] r3_q, r4_q;
  logic [15:0] lo4_q, hi4_q, lo5_q, lo6_q;
  logic [XW-1:0] x5_q;
  logic [PR2W-1:0] pr2_q;
  logic signed [LN_W-1:0] ln7_q;

  // Stage 3, 5 and 7 combinational terms
  logic [IW-1:0]    i_d;
  logic [PW-1:0]    iq_d;
  logic [HUM_W-1:0] r_d;
  logic [15:0]      dl_d;
  logic [16:0]      q2_d;
  logic [LN_W-1:0]  ln_d;

  always_comb begin
    i_d  = IW'(pr1_q >> S1);
    iq_d = PW'(i_d) * PW'(RH_FULL);
    r_d  = HUM_W'(p2_q - iq_d);
    dl_d = hi4_q - lo4_q;
    q2_d = 17'(pr2_q >> S2);
    ln_d = LN_W'(lo6_q) + LN_W'(q2_d) - LN_W'(32'(e6_q) * 32'(LN2_Q16));
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= side_i; e1_q <= e_d; p1_q <= p_d;
      // reciprocal multiply for the table index
      s2_q <= s1_q; e2_q <= e1_q; p2_q <= p1_q;
      pr1_q <= PR1W'(p1_q) * PR1W'(M1);
      s3_q <= s2_q; e3_q <= e2_q; i3_q <= i_d; r3_q <= r_d;
      // table read
      s4_q <= s3_q; e4_q <= e3_q; r4_q <= r3_q;
      lo4_q <= ln_rom[AW'(i3_q)];
      hi4_q <= ln_rom[AW'(i3_q) + AW'(1)];
      // interpolation
      s5_q <= s4_q; e5_q <= e4_q; lo5_q <= lo4_q;
      x5_q <= XW'(dl_d) * XW'(r4_q);
      s6_q <= s5_q; e6_q <= e5_q; lo6_q <= lo5_q;
      pr2_q <= PR2W'(x5_q) * PR2W'(M2);
      s7_q <= s6_q; ln7_q <= ln_d;
    end
  end

  assign valid_o     = v7_q;
  assign lnside_o.s  = s7_q;
  assign lnside_o.ln = ln7_q;

endmodule

// ----- src/ccc_div.sv -----
// Pipelined radix-2 restoring divider for the Magnus term A*T*2^16 / (100*(B+T)).
// One prepare stage, then one quotient bit per stage. Depends on ccc_pkg.
module ccc_div import ccc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  lnside_t           lnside_i,
  output logic              valid_o,
  output lnside_t           lnside_o,
  output logic [QUOT_W-1:0] quot_o,
  output logic              neg_o
);

  // Prepare magnitude of the dividend and the divisor
  logic [TEMP_W:0]   t16;
  logic [TEMP_W:0]   at16;
  logic [24:0]       a_d;
  logic [NUM_W-1:0]  n_d;
  logic [16:0]       bt_d;
  logic [DIV_W-1:0]  d_d;

  always_comb begin
    t16  = {lnside_i.s.t[TEMP_W-1], lnside_i.s.t};
    at16 = lnside_i.s.t[TEMP_W-1] ? (TEMP_W+1)'(-t16) : t16;
    a_d  = 25'(at16) * 25'(MAG_A_CENTI);
    n_d  = {a_d, 16'b0};
    bt_d = 17'(MAG_B_CENTI) + t16[16-1:0] + {t16[TEMP_W], 16'b0};
    d_d  = DIV_W'(bt_d) * DIV_W'(100);
  end

  logic              v_q   [QUOT_W+1];
  logic [DIV_W-1:0]  rem_q [QUOT_W+1];
  logic [QUOT_W-1:0] nb_q  [QUOT_W+1];
  logic [QUOT_W-1:0] q_q   [QUOT_W+1];
  logic [DIV_W-1:0]  d_q   [QUOT_W+1];
  logic              neg_q [QUOT_W+1];
  lnside_t           sd_q  [QUOT_W+1];

  // Load the prepare stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DIV_W'(n_d[NUM_W-1:QUOT_W]);
      nb_q[0]  <= n_d[QUOT_W-1:0];
      q_q[0]   <= '0;
      d_q[0]   <= d_d;
      neg_q[0] <= lnside_i.s.t[TEMP_W-1];
      sd_q[0]  <= lnside_i;
    end
  end

  // One quotient bit per stage
  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    logic [DIV_W:0] trial;
    logic           ge;

    assign trial = {rem_q[s], nb_q[s][QUOT_W-1]};
    assign ge    = trial >= {1'b0, d_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? DIV_W'(trial - {1'b0, d_q[s]}) : trial[DIV_W-1:0];
        nb_q[s+1]  <= nb_q[s] << 1;
        q_q[s+1]   <= {q_q[s][QUOT_W-2:0], ge};
        d_q[s+1]   <= d_q[s];
        neg_q[s+1] <= neg_q[s];
        sd_q[s+1]  <= sd_q[s];
      end
    end
  end

  assign valid_o  = v_q[QUOT_W];
  assign lnside_o = sd_q[QUOT_W];
  assign quot_o   = q_q[QUOT_W];
  assign neg_o    = neg_q[QUOT_W];

endmodule

// ----- src/ccc_decide.sv -----
// Dew point versus window surface comparison and the fan and heater rules.
// Five register stages. Depends on ccc_pkg.
module ccc_decide import ccc_pkg::*; #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  lnside_t           lnside_i,
  input  logic [QUOT_W-1:0] quot_i,
  input  logic              neg_i,
  input  lim_t              lim_i,
  output logic              valid_o,
  output result_t           res_o
);

  localparam int AL_W  = 24;
  localparam int DEN_W = 22;
  localparam int NM_W  = 40;
  localparam int TD_W  = 38;
  localparam int PDD_W = 56;
  localparam int DF_W  = 41;
  localparam int LHS_W = DF_W + RATIO_FRAC_BITS;
  localparam int CMP_W = ((LHS_W > PDD_W) ? LHS_W : PDD_W) + 1;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  side_t s1_q, s2_q, s3_q, s4_q;
  logic signed [AL_W-1:0]  alpha1_q;
  logic [DEN_W-1:0]        den2_q;
  logic signed [NM_W-1:0]  num2_q, num3_q;
  logic signed [TD_W-1:0]  td3_q;
  logic signed [PDD_W-1:0] pdd3_q, pdd4_q;
  logic signed [DF_W-1:0]  df4_q;
  result_t                 res5_q;

  // Combinational terms of each stage
  logic signed [QUOT_W:0]  term_d;
  logic signed [AL_W-1:0]  alpha_d;
  logic signed [AL_W:0]    dens_d;
  logic [DEN_W-1:0]        den_d;
  logic signed [NM_W-1:0]  num_d;
  logic signed [TD_W-1:0]  td_d;
  logic signed [PDD_W-1:0] pdd_d;
  logic signed [DF_W-1:0]  df_d;
  logic signed [CMP_W-1:0] lhs_d;
  logic signed [CMP_W-1:0] rhs_d;
  logic                    risk_d;
  logic                    fan_d;
  logic                    heat_d;

  always_comb begin
    term_d  = neg_i ? -$signed({1'b0, quot_i}) : $signed({1'b0, quot_i});
    alpha_d = AL_W'(term_d) + AL_W'(lnside_i.ln);
    dens_d  = (AL_W+1)'(MAG_A_Q16) - {alpha1_q[AL_W-1], alpha1_q};
    // a non-positive denominator is forced to one
    den_d   = (dens_d <= 0) ? DEN_W'(1) : DEN_W'(dens_d);
    num_d   = NM_W'(alpha1_q) * NM_W'(MAG_B_CENTI);
    td_d    = TD_W'(s2_q.t) * $signed({16'b0, den2_q});
    pdd_d   = PDD_W'(s2_q.pd) * $signed({34'b0, den2_q});
    df_d    = DF_W'(td3_q) - DF_W'(num3_q);
    lhs_d   = CMP_W'(df4_q) <<< RATIO_FRAC_BITS;
    rhs_d   = CMP_W'(pdd4_q);
    risk_d  = lhs_d < rhs_d;
    // fan and heater rules
    fan_d  = risk_d;
    heat_d = 1'b0;
    if (s4_q.t < lim_i.t_lo) begin
      heat_d = 1'b1;
    end else if (s4_q.t > lim_i.t_hi) begin
      fan_d = 1'b1;
    end
    if (s4_q.h > lim_i.h_hi) begin
      fan_d = 1'b1;
    end else if (s4_q.h < lim_i.h_lo && !risk_d && s4_q.t <= lim_i.t_hi) begin
      fan_d = 1'b0;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= lnside_i.s; alpha1_q <= alpha_d;
      s2_q <= s1_q; den2_q <= den_d; num2_q <= num_d;
      s3_q <= s2_q; td3_q <= td_d; pdd3_q <= pdd_d; num3_q <= num2_q;
      s4_q <= s3_q; df4_q <= df_d; pdd4_q <= pdd3_q;
      res5_q.idx  <= s4_q.idx;
      res5_q.fan  <= fan_d;
      res5_q.heat <= heat_d;
      res5_q.risk <= risk_d;
    end
  end

  assign valid_o = v5_q;
  assign res_o   = res5_q;

endmodule

// ----- src/chamber_condensation_climate_control.sv -----
// Chamber condensation climate control: takes one reading per clock while not stalled
// (chamber temperature, humidity, outdoor temperature) and returns fan, heater and
// condensation-risk commands. The pipeline is 36 register stages deep ahead of the output
// register; the length is set mostly by the 23-stage radix-2 divider (one prepare stage
// and 22 quotient bits) for the Magnus temperature term, with seven stages of ln(RH/100)
// table lookup ahead of it. One reading enters every cycle while the input stall is low.
// A one-word skid register behind the output register absorbs a stall; while it holds a
// word the input stall is raised and the whole pipeline holds.
// Configuration writes are taken at any time but belong in idle periods.
module chamber_condensation_climate_control import ccc_pkg::*; #(
  parameter int LN_TABLE_DEPTH  = 256,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IW-1:0]        cfg_idx_i,
  input  logic [CFG_DW-1:0]        cfg_data_i,
  // readings
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [IDX_W-1:0]         chamber_index_i,
  input  logic signed [TEMP_W-1:0] chamber_temp_i,
  input  logic [HUM_W-1:0]         chamber_humid_i,
  input  logic signed [TEMP_W-1:0] outdoor_temp_i,
  // commands
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IDX_W-1:0]         chamber_out_o,
  output logic                     fan_on_o,
  output logic                     heater_on_o,
  output logic                     condensation_risk_o
);

  logic [RATIO_W-1:0] ratio_q;
  lim_t               lim_q;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q    <= 16'd32768;
      lim_q.t_lo <= 15'sd1500;
      lim_q.t_hi <= 15'sd3000;
      lim_q.h_lo <= 14'd3000;
      lim_q.h_hi <= 14'd7000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SURF_RATIO: ratio_q    <= cfg_data_i;
        REG_TEMP_LOW:   lim_q.t_lo <= cfg_data_i[TEMP_W-1:0];
        REG_TEMP_HIGH:  lim_q.t_hi <= cfg_data_i[TEMP_W-1:0];
        REG_HUMID_LOW:  lim_q.h_lo <= cfg_data_i[HUM_W-1:0];
        REG_HUMID_HIGH: lim_q.h_hi <= cfg_data_i[HUM_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q;
  logic out_v_q;
  result_t skid_q;
  result_t out_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // Input stage: capture the word and form (T_in - T_out) * ratio
  logic signed [TEMP_W:0] tdiff_d;
  logic signed [PD_W-1:0] pd_d;
  logic                   v0_q;
  side_t                  side0_q;

  always_comb begin
    tdiff_d = (TEMP_W+1)'(chamber_temp_i) - (TEMP_W+1)'(outdoor_temp_i);
    pd_d    = tdiff_d * $signed({1'b0, ratio_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side0_q.idx <= chamber_index_i;
      side0_q.t   <= chamber_temp_i;
      side0_q.h   <= chamber_humid_i;
      side0_q.pd  <= pd_d;
    end
  end

  logic              ln_v;
  lnside_t           ln_side;
  logic              div_v;
  lnside_t           div_side;
  logic [QUOT_W-1:0] div_quot;
  logic              div_neg;
  logic              dec_v;
  result_t           dec_res;

  ccc_ln #(
    .LN_TABLE_DEPTH(LN_TABLE_DEPTH)
  ) u_ln (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v0_q),
    .side_i   (side0_q),
    .valid_o  (ln_v),
    .lnside_o (ln_side)
  );

  ccc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (ln_v),
    .lnside_i (ln_side),
    .valid_o  (div_v),
    .lnside_o (div_side),
    .quot_o   (div_quot),
    .neg_o    (div_neg)
  );

  ccc_decide #(
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (div_v),
    .lnside_i (div_side),
    .quot_i   (div_quot),
    .neg_i    (div_neg),
    .lim_i    (lim_q),
    .valid_o  (dec_v),
    .res_o    (dec_res)
  );

  // Output register with a one-word skid behind it
  logic take;
  assign take = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_v_q || take) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (dec_v) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (!out_v_q || take) begin
        out_q <= skid_q;
      end
    end else if (dec_v) begin
      if (!out_v_q || take) begin
        out_q <= dec_res;
      end else begin
        skid_q <= dec_res;
      end
    end
  end

  assign out_valid_o         = out_v_q;
  assign chamber_out_o       = out_q.idx;
  assign fan_on_o            = out_q.fan;
  assign heater_on_o         = out_q.heat;
  assign condensation_risk_o = out_q.risk;

  // The skid only fills behind a held output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q) && $past(out_stall_i))
    else $error("skid filled while output register was free");

  // A full skid implies a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a word ahead of an empty output register");

  // A taken output word lets the skid drain into the output register in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_stall_i |=> out_v_q && !skid_v_q)
    else $error("skid did not drain after output was taken");

endmodule
